// ===== design/isort_pkg.sv =====
// Shared constants and control types for the insertion sort engine.
`timescale 1ns / 1ps

package isort_pkg;

   localparam int DEFAULT_DEPTH      = 16;
   localparam int DEFAULT_DATA_WIDTH = 32;

   // Store write data selection
   localparam logic [1:0] WSEL_INPUT = 2'd0;
   localparam logic [1:0] WSEL_KEY   = 2'd1;
   localparam logic [1:0] WSEL_READ  = 2'd2;

   typedef struct packed {
      logic       wr_en;
      logic [1:0] wr_sel;
      logic       rd_en;
      logic       key_load;
      logic       out_load;
      logic       out_last;
      logic       out_ovf;
   } cmd_type;

   typedef struct packed {
      logic greater;    // store read data > key, signed
      logic out_free;   // output register can take a result this cycle
   } status_type;

endpackage

// ===== design/isort_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module isort_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/isort_dp.sv =====
// Datapath: element store, key register, signed compare and output register.
`timescale 1ns / 1ps

module isort_dp #(
   parameter int DEPTH      = isort_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = isort_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  isort_pkg::cmd_type        cmd,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   input  logic [DATA_WIDTH-1:0]     in_value,
   input  logic                      out_ready,
   output isort_pkg::status_type     status,
   output logic [DATA_WIDTH-1:0]     out_data,
   output logic                      out_last,
   output logic                      out_ovf,
   output logic                      out_valid
);

   logic [DATA_WIDTH-1:0] rd_data;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [DATA_WIDTH-1:0] out_data_ff, out_data_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_ovf_ff, out_ovf_in;
   logic                  out_valid_ff, out_valid_in;

   isort_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      case (cmd.wr_sel)
         isort_pkg::WSEL_INPUT: wr_data = in_value;
         isort_pkg::WSEL_KEY:   wr_data = key_ff;
         isort_pkg::WSEL_READ:  wr_data = rd_data;
         default:               wr_data = rd_data;
      endcase
   end

   always_comb begin
      key_in       = cmd.key_load ? rd_data : key_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_data_in  = rd_data;
         out_last_in  = cmd.out_last;
         out_ovf_in   = cmd.out_ovf;
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.greater  = $signed(rd_data) > $signed(key_ff);
   assign status.out_free = !out_valid_ff || out_ready;
   assign out_data        = out_data_ff;
   assign out_last        = out_last_ff;
   assign out_ovf         = out_ovf_ff;
   assign out_valid       = out_valid_ff;

endmodule

// ===== design/isort_ctrl.sv =====
// Controller: load, insertion sort and emit sequencing with loop counters.
`timescale 1ns / 1ps

module isort_ctrl #(
   parameter int DEPTH = isort_pkg::DEFAULT_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic                      in_last,
   output logic                      in_ready,
   input  isort_pkg::status_type     status,
   output isort_pkg::cmd_type        cmd,
   output logic [$clog2(DEPTH)-1:0]  wr_addr,
   output logic [$clog2(DEPTH)-1:0]  rd_addr
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [2:0] ST_LOAD     = 3'd0;
   localparam logic [2:0] ST_SORT_I   = 3'd1;
   localparam logic [2:0] ST_KEY      = 3'd2;
   localparam logic [2:0] ST_SCAN     = 3'd3;
   localparam logic [2:0] ST_PLACE0   = 3'd4;
   localparam logic [2:0] ST_EMIT_RD  = 3'd5;
   localparam logic [2:0] ST_EMIT_PUT = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic              dropped_ff, dropped_in;
   logic              emit_last;

   assign emit_last = (CNT_W'(k_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      dropped_in = dropped_ff;
      in_ready   = 1'b0;
      cmd        = '0;
      cmd.wr_sel = isort_pkg::WSEL_INPUT;
      wr_addr    = '0;
      rd_addr    = '0;
      case (state_ff)
         ST_LOAD: begin
            in_ready = 1'b1;
            if (in_valid) begin
               if (count_ff < CNT_W'(DEPTH)) begin
                  cmd.wr_en = 1'b1;
                  wr_addr   = count_ff[ADDR_W-1:0];
                  count_in  = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (in_last) begin
                  i_in     = CNT_W'(1);
                  state_in = ST_SORT_I;
               end
            end
         end
         ST_SORT_I: begin
            if (i_ff >= count_ff) begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = i_ff[ADDR_W-1:0];
               state_in  = ST_KEY;
            end
         end
         ST_KEY: begin
            cmd.key_load = 1'b1;
            cmd.rd_en    = 1'b1;
            rd_addr      = ADDR_W'(i_ff - CNT_W'(1));
            j_in         = ADDR_W'(i_ff - CNT_W'(1));
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.wr_en = 1'b1;
            wr_addr   = j_ff + ADDR_W'(1);
            if (status.greater) begin
               cmd.wr_sel = isort_pkg::WSEL_READ;
               if (j_ff == '0) begin
                  state_in = ST_PLACE0;
               end else begin
                  j_in      = j_ff - ADDR_W'(1);
                  cmd.rd_en = 1'b1;
                  rd_addr   = j_ff - ADDR_W'(1);
               end
            end else begin
               cmd.wr_sel = isort_pkg::WSEL_KEY;
               i_in       = i_ff + CNT_W'(1);
               state_in   = ST_SORT_I;
            end
         end
         ST_PLACE0: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = isort_pkg::WSEL_KEY;
            wr_addr    = '0;
            i_in       = i_ff + CNT_W'(1);
            state_in   = ST_SORT_I;
         end
         ST_EMIT_RD: begin
            cmd.rd_en = 1'b1;
            rd_addr   = k_ff;
            state_in  = ST_EMIT_PUT;
         end
         ST_EMIT_PUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = emit_last;
               cmd.out_ovf  = dropped_ff;
               if (emit_last) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  k_in      = k_ff + ADDR_W'(1);
                  cmd.rd_en = 1'b1;
                  rd_addr   = k_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         i_ff       <= '0;
         j_ff       <= '0;
         k_ff       <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         k_ff       <= k_in;
         dropped_ff <= dropped_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count beyond store depth");

   a_scan_below_i: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (CNT_W'(j_ff) < i_ff) && (i_ff < count_ff))
      else $error("scan index out of sorted window");

   a_no_write_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_PUT) |-> !cmd.wr_en)
      else $error("store written while emitting");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT_PUT |-> CNT_W'(k_ff) < count_ff)
      else $error("emit index beyond list length");

endmodule

// ===== design/insertion_sort_engine_core.sv =====
// Top level of the insertion sort engine.
`timescale 1ns / 1ps

// Collects a list of signed values, one per input transfer, into a store of
// DEPTH entries; the transfer with tlast closes the list. Elements beyond DEPTH
// are dropped and every result of that list carries the overflow flag in tuser.
// The list is sorted ascending and stable, then sent out with tlast on the final
// result. Loading takes one element per cycle. Sorting runs on the store's one
// read and one write port and makes at most n(n-1)/2 element moves for n
// elements. Input is not accepted while a list sorts or is sent out.
module insertion_sort_engine_core #(
   parameter int DEPTH      = isort_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = isort_pkg::DEFAULT_DATA_WIDTH,
   localparam int TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // value
   input  logic               req_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // sorted_value
   output logic               rsp_tlast,
   output logic [0:0]         rsp_tuser    // overflow
);

   isort_pkg::cmd_type             cmd;
   isort_pkg::status_type          status;
   logic [$clog2(DEPTH)-1:0]       wr_addr;
   logic [$clog2(DEPTH)-1:0]       rd_addr;
   logic [DATA_WIDTH-1:0]          out_data;
   logic                           out_ovf;

   isort_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_last  (req_tlast),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd),
      .wr_addr  (wr_addr),
      .rd_addr  (rd_addr)
   );

   isort_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .in_value  (req_tdata[DATA_WIDTH-1:0]),
      .out_ready (rsp_tready),
      .status    (status),
      .out_data  (out_data),
      .out_last  (rsp_tlast),
      .out_ovf   (out_ovf),
      .out_valid (rsp_tvalid)
   );

   assign rsp_tdata    = TDATA_W'(out_data);
   assign rsp_tuser[0] = out_ovf;

endmodule

// ===== verif/isort_checker.sv =====
// Checker for the insertion sort engine: predicts sorted lists and compares results.
`timescale 1ns / 1ps

module isort_checker #(
   parameter int DEPTH      = isort_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = isort_pkg::DEFAULT_DATA_WIDTH,
   localparam int TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // value
   input  logic               req_tlast,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [TDATA_W-1:0] rsp_tdata,   // sorted_value
   input  logic               rsp_tlast,
   input  logic [0:0]         rsp_tuser,   // overflow
   output int                 mismatch_count,
   output int                 outstanding,
   output int                 lists_closed,
   output int                 results_seen,
   output int                 overflow_lists
);

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last;
      logic                         ovf;
   } sorted_entry_type;

   logic signed [DATA_WIDTH-1:0] list_buf [DEPTH];
   int                           list_len     = 0;
   bit                           list_dropped = 1'b0;
   sorted_entry_type             sorted_q [$];
   sorted_entry_type             want;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      lists_closed   = 0;
      results_seen   = 0;
      overflow_lists = 0;
   end

   // stable insertion sort of the held list, then queue one entry per element
   function automatic void queue_sorted_list();
      logic signed [DATA_WIDTH-1:0] work [DEPTH];
      logic signed [DATA_WIDTH-1:0] tmp;
      sorted_entry_type             e;
      int                           i;
      int                           j;
      work = list_buf;
      for (i = 1; i < list_len; i++) begin
         for (j = i; j > 0 && work[j-1] > work[j]; j--) begin
            tmp       = work[j-1];
            work[j-1] = work[j];
            work[j]   = tmp;
         end
      end
      for (i = 0; i < list_len; i++) begin
         e.value = work[i];
         e.last  = (i == list_len - 1);
         e.ovf   = list_dropped;
         sorted_q.push_back(e);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         list_len     = 0;
         list_dropped = 1'b0;
         sorted_q.delete();
         outstanding <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (sorted_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result value=%0d last=%b ovf=%b",
                           $realtime, $signed(rsp_tdata[DATA_WIDTH-1:0]), rsp_tlast,
                           rsp_tuser[0]);
            end else begin
               want = sorted_q.pop_front();
               if (rsp_tdata[DATA_WIDTH-1:0] !== want.value || rsp_tlast !== want.last ||
                   rsp_tuser[0] !== want.ovf) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: result mismatch exp value=%0d last=%b ovf=%b,",
                               " got value=%0d last=%b ovf=%b"},
                              $realtime, want.value, want.last, want.ovf,
                              $signed(rsp_tdata[DATA_WIDTH-1:0]), rsp_tlast, rsp_tuser[0]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (list_len < DEPTH) begin
               list_buf[list_len] = req_tdata[DATA_WIDTH-1:0];
               list_len++;
            end else begin
               list_dropped = 1'b1;
            end
            if (req_tlast) begin
               queue_sorted_list();
               lists_closed++;
               if (list_dropped)
                  overflow_lists++;
               list_len     = 0;
               list_dropped = 1'b0;
            end
         end
         outstanding <= sorted_q.size();
      end
   end

endmodule

// ===== verif/tb_insertion_sort_engine_core.sv =====
// Testbench top for the insertion sort engine: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_insertion_sort_engine_core;

   localparam int DEPTH = isort_pkg::DEFAULT_DEPTH;
   localparam int DW    = isort_pkg::DEFAULT_DATA_WIDTH;
   localparam int TW    = ((DW + 7) / 8) * 8;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [TW-1:0] req_tdata  = '0;   // value
   logic          req_tlast  = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [TW-1:0] rsp_tdata;         // sorted_value
   logic          rsp_tlast;
   logic [0:0]    rsp_tuser;         // overflow

   int mismatch_count;
   int outstanding;
   int lists_closed;
   int results_seen;
   int overflow_lists;

   bit            tx_quiet  = 1'b0;
   bit            rx_quiet  = 1'b0;
   bit            hold_rsp  = 1'b0;
   int            items_sent = 0;
   logic [DW-1:0] list_vals [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   insertion_sort_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   isort_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .lists_closed   (lists_closed),
      .results_seen   (results_seen),
      .overflow_lists (overflow_lists)
   );

   function automatic logic [DW-1:0] pick_value();
      case ($urandom_range(3))
         0: return DW'($signed($urandom_range(8)) - 4);
         1: case ($urandom_range(3))
               0: return {1'b1, {(DW-1){1'b0}}};
               1: return {1'b0, {(DW-1){1'b1}}};
               2: return '0;
               default: return '1;
            endcase
         default: return DW'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic [DW-1:0] v, input logic l);
      while (!tx_quiet && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TW'(v);
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_list();
      int k;
      for (k = 0; k < list_vals.size(); k++)
         send_item(list_vals[k], k == list_vals.size() - 1);
   endtask

   // receiver flow control
   initial begin
      wait (!reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_tready <= rx_quiet || ($urandom_range(99) >= 38);
            @(posedge clock);
         end
      end
   end

   initial begin
      #3ms;
      $display("timeout with %0d results outstanding", outstanding);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int list_idx;
      int len;
      int k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // single element at the positive extreme
      list_vals = '{{1'b0, {(DW-1){1'b1}}}};
      send_list();
      // extremes, zero, +-1 and a repeated minimum
      list_vals = '{{1'b1, {(DW-1){1'b0}}}, {1'b0, {(DW-1){1'b1}}}, '1, '0, DW'(1),
                    {1'b1, {(DW-1){1'b0}}}};
      send_list();
      // full store, then two dropped elements; the closing one is dropped too
      list_vals.delete();
      for (k = 0; k < DEPTH + 2; k++)
         list_vals.push_back(DW'($urandom));
      send_list();

      list_idx = 0;
      while (items_sent < 200) begin
         tx_quiet = (list_idx >= 4 && list_idx < 8);
         rx_quiet = tx_quiet;
         if (list_idx == 10)
            hold_rsp = 1'b1;
         len = ($urandom_range(7) == 0) ? $urandom_range(DEPTH + 4, DEPTH + 1)
                                        : $urandom_range(DEPTH, 1);
         list_vals.delete();
         for (k = 0; k < len; k++)
            list_vals.push_back(pick_value());
         send_list();
         if (list_idx == 14) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end
         list_idx++;
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (50) @(posedge clock);

      $display("sent %0d elements in %0d lists (%0d with dropped elements)",
               items_sent, lists_closed, overflow_lists);
      $display("checked %0d sorted results, %0d mismatches", results_seen, mismatch_count);
      if (mismatch_count == 0 && outstanding == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
